// ===== hw/rtl/abst_pkg.sv =====
package abst_pkg;

  localparam int TREE_LEVELS_DEF = 10;
  localparam int SLOT_COUNT_DEF  = 1023;
  localparam int KEY_W           = 32;
  localparam int SLOT_W          = 10;
  localparam int COUNT_W         = 10;
  localparam int CODE_W          = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CODE_W-1:0] {
    CODE_INSERTED  = 3'd0,
    CODE_PRESENT   = 3'd1,
    CODE_FULL      = 3'd2,
    CODE_FOUND     = 3'd3,
    CODE_NOT_FOUND = 3'd4,
    CODE_ZERO      = 3'd5
  } abst_code_t;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key_value;
  } abst_req_t;

  typedef struct packed {
    logic [CODE_W-1:0]  status;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] stored_count;
  } abst_rsp_t;

  typedef struct packed {
    logic       clear_wr;
    logic       load;
    logic       advance;
    logic       insert;
    logic       finish;
    logic       take_slot;
    abst_code_t code;
    logic       publish;
  } abst_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic key_zero;
    logic is_search;
    logic slot_empty;
    logic slot_match;
    logic path_end;
    logic out_busy;
  } abst_sts_t;

endpackage

// ===== hw/rtl/abst_ctrl.sv =====
module abst_ctrl import abst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  abst_sts_t sts,
  output abst_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.code = CODE_ZERO;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (sts.key_zero) begin
            cmd.finish = 1'b1;
            cmd.code   = CODE_ZERO;
          end
        end
      end
      S_WALK: begin
        if (sts.slot_empty) begin
          cmd.finish = 1'b1;
          if (sts.is_search) begin
            cmd.code = CODE_NOT_FOUND;
          end else begin
            cmd.insert    = 1'b1;
            cmd.take_slot = 1'b1;
            cmd.code      = CODE_INSERTED;
          end
        end else if (sts.slot_match) begin
          cmd.finish    = 1'b1;
          cmd.take_slot = 1'b1;
          cmd.code      = sts.is_search ? CODE_FOUND : CODE_PRESENT;
        end else if (sts.path_end) begin
          cmd.finish = 1'b1;
          cmd.code   = sts.is_search ? CODE_NOT_FOUND : CODE_FULL;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_DONE: begin
        cmd.publish = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sts.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) state <= sts.key_zero ? S_DONE : S_WALK;
        end
        S_WALK: begin
          if (sts.slot_empty || sts.slot_match || sts.path_end) state <= S_DONE;
        end
        S_DONE: begin
          if (!sts.out_busy) state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/abst_dp.sv =====
module abst_dp import abst_pkg::*; #(
  parameter int TREE_LEVELS = TREE_LEVELS_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  abst_req_t req_data,
  input  logic      rsp_ready,
  output logic      rsp_valid,
  output abst_rsp_t rsp_data,
  input  abst_cmd_t cmd,
  output abst_sts_t sts
);

  localparam int ADDR_W = $clog2(SLOT_COUNT);
  localparam int NEXT_W = ADDR_W + 2;
  localparam int LVL_W  = $clog2(TREE_LEVELS);

  logic signed [KEY_W-1:0] tree [0:SLOT_COUNT-1];

  logic signed [KEY_W-1:0] key;
  logic                    is_search;
  logic [ADDR_W-1:0]       pos;
  logic [LVL_W-1:0]        level;
  logic [COUNT_W-1:0]      count;
  abst_code_t              res_code;
  logic [SLOT_W-1:0]       res_slot;
  logic signed [KEY_W-1:0] rd_data;
  logic [ADDR_W-1:0]       clr_addr;

  logic                    go_right;
  logic [NEXT_W-1:0]       pos_wide;
  logic [NEXT_W-1:0]       next_pos;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  // larger keys go to the right child
  assign go_right = key > rd_data;
  assign pos_wide = NEXT_W'(pos);
  assign next_pos = (pos_wide << 1) + (go_right ? NEXT_W'(2) : NEXT_W'(1));

  assign rd_addr = cmd.load ? '0 : next_pos[ADDR_W-1:0];
  assign wr_en   = cmd.clear_wr || cmd.insert;
  assign wr_addr = cmd.clear_wr ? clr_addr : pos;
  assign wr_data = cmd.clear_wr ? '0 : key;

  assign sts.clear_last = (clr_addr == ADDR_W'(SLOT_COUNT - 1));
  assign sts.key_zero   = (req_data.key_value == '0);
  assign sts.is_search  = is_search;
  assign sts.slot_empty = (rd_data == '0);
  assign sts.slot_match = (rd_data == key);
  assign sts.path_end   = (level == LVL_W'(TREE_LEVELS - 1)) ||
                          (next_pos >= NEXT_W'(SLOT_COUNT));
  assign sts.out_busy   = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree[wr_addr] <= wr_data;
    end
    rd_data <= tree[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_addr <= clr_addr + ADDR_W'(1);
      if (cmd.insert && count != COUNT_MAX) count <= count + COUNT_W'(1);
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key       <= req_data.key_value;
      is_search <= req_data.mode;
      pos       <= '0;
      level     <= '0;
    end else if (cmd.advance) begin
      pos   <= next_pos[ADDR_W-1:0];
      level <= level + LVL_W'(1);
    end
    if (cmd.finish) begin
      res_code <= cmd.code;
      res_slot <= cmd.take_slot ? SLOT_W'(pos) : '0;
    end
    if (cmd.publish) begin
      rsp_data.status       <= res_code;
      rsp_data.slot_index   <= res_slot;
      rsp_data.stored_count <= count;
    end
  end

endmodule

// ===== hw/rtl/array_bst_insert_search_core.sv =====
// a zero key is answered without a tree walk; other keys walk the tree from the root,
// visiting 1 to TREE_LEVELS levels
// one request at a time: req_ready stays low until the response of the last request
// is published, with one read of the single slot memory per level
// reset: the slot memory is cleared one slot per cycle,
// with req_ready low until the pass is done
module array_bst_insert_search_core import abst_pkg::*; #(
  parameter int TREE_LEVELS = TREE_LEVELS_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  abst_req_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output abst_rsp_t rsp_data
);

  abst_cmd_t cmd;
  abst_sts_t sts;

  abst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  abst_dp #(
    .TREE_LEVELS (TREE_LEVELS),
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import abst_pkg::*;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;
  localparam int RANDOM_REQS = 1130;
  localparam int QUIET_TAIL = 150;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    bit        drain;
    abst_req_t req;
  } pending_req_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  abst_req_t req_data = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  abst_rsp_t rsp_data;

  pending_req_t            pending_reqs[$];
  abst_rsp_t               expected_rsps[$];
  logic signed [KEY_W-1:0] key_pool[$];
  logic signed [KEY_W-1:0] tree_keys[SLOT_COUNT_DEF];
  logic [COUNT_W-1:0]      held_count = '0;

  int send_gap = 0;
  int recv_gap = 0;
  int n_accepted = 0;
  int fail_count = 0;
  int stall_cycles = 0;
  int status_seen[6] = '{default: 0};

  array_bst_insert_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // walks the tree like the block does and applies an insert for insert requests
  function automatic abst_rsp_t bst_apply(input abst_req_t r);
    abst_rsp_t               res;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] here;
    int unsigned             pos;
    int                      lvl;
    bit                      done;
    res = '0;
    key = r.key_value;
    if (key == 0) begin
      res.status = CODE_ZERO;
    end else begin
      res.status = (r.mode == MODE_SEARCH) ? CODE_NOT_FOUND : CODE_FULL;
      pos = 0;
      lvl = 0;
      done = 1'b0;
      while (!done && lvl < TREE_LEVELS_DEF && pos < SLOT_COUNT_DEF) begin
        here = tree_keys[pos];
        if (here == 0) begin
          if (r.mode == MODE_INSERT) begin
            tree_keys[pos] = key;
            if (held_count != COUNT_MAX) held_count++;
            res.status = CODE_INSERTED;
            res.slot_index = pos[SLOT_W-1:0];
          end
          done = 1'b1;
        end else if (here == key) begin
          res.status = (r.mode == MODE_SEARCH) ? CODE_FOUND : CODE_PRESENT;
          res.slot_index = pos[SLOT_W-1:0];
          done = 1'b1;
        end else begin
          pos = (key > here) ? 2 * pos + 2 : 2 * pos + 1;
          lvl++;
        end
      end
    end
    res.stored_count = held_count;
    return res;
  endfunction

  // no idling near the end and in some stretches in the middle
  function automatic bit take_break();
    if (pending_reqs.size() < QUIET_TAIL || (pending_reqs.size() / 128) % 5 == 2) begin
      return 1'b0;
    end
    return $urandom_range(0, 5) == 0;
  endfunction

  task automatic queue_req(input bit drain, input logic mode,
                           input logic signed [KEY_W-1:0] key);
    pending_req_t p;
    p.drain = drain;
    p.req.mode = mode;
    p.req.key_value = key;
    pending_reqs.push_back(p);
    if (mode == MODE_INSERT && key != 0) key_pool.push_back(key);
  endtask

  always @(posedge clk) begin : req_side
    pending_req_t next_req;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(bst_apply(req_data));
        n_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain && expected_rsps.size() != 0)) begin
          req_valid <= 1'b0;
        end else if (take_break()) begin
          send_gap <= $urandom_range(0, 8);
          req_valid <= 1'b0;
        end else begin
          next_req = pending_reqs.pop_front();
          req_valid <= 1'b1;
          req_data <= next_req.req;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_side
    abst_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response: status %0d slot_index %0d stored_count %0d",
                 rsp_data.status, rsp_data.slot_index, rsp_data.stored_count);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          status_seen[want.status]++;
          if (rsp_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
            fail_count++;
          end
          if (rsp_data.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d",
                   want.slot_index, rsp_data.slot_index);
            fail_count++;
          end
          if (rsp_data.stored_count !== want.stored_count) begin
            $error("stored_count: expected %0d, actual %0d",
                   want.stored_count, rsp_data.stored_count);
            fail_count++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        rsp_ready <= 1'b0;
      end else if (take_break()) begin
        recv_gap <= $urandom_range(0, 8);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int                      roll;
    logic signed [KEY_W-1:0] k;
    foreach (tree_keys[i]) tree_keys[i] = '0;

    // empty tree, zero keys, extremes at the top
    queue_req(1'b0, MODE_SEARCH, 5);
    queue_req(1'b0, MODE_INSERT, 0);
    queue_req(1'b0, MODE_SEARCH, 0);
    queue_req(1'b0, MODE_INSERT, 1);
    queue_req(1'b0, MODE_INSERT, 32'h8000_0000);
    queue_req(1'b0, MODE_INSERT, 32'h7fff_ffff);
    // zigzag path down to the last level, then one step too deep
    queue_req(1'b0, MODE_INSERT, 1000);
    queue_req(1'b0, MODE_INSERT, 2000);
    queue_req(1'b0, MODE_INSERT, 1500);
    queue_req(1'b0, MODE_INSERT, 1750);
    queue_req(1'b0, MODE_INSERT, 1600);
    queue_req(1'b0, MODE_INSERT, 1700);
    queue_req(1'b0, MODE_INSERT, 1650);
    queue_req(1'b0, MODE_INSERT, 1680);
    queue_req(1'b0, MODE_INSERT, 1670);
    queue_req(1'b0, MODE_SEARCH, 1670);
    queue_req(1'b0, MODE_INSERT, 1700);
    queue_req(1'b0, MODE_SEARCH, 1680);
    queue_req(1'b0, MODE_SEARCH, 32'h8000_0000);
    queue_req(1'b0, MODE_SEARCH, -5);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      case ($urandom_range(0, 3))
        0: k = $urandom;
        1, 2: k = $signed($urandom_range(0, 4000)) - 2000;
        default: k = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 40)
                                          : 32'h8000_0000 + $urandom_range(0, 40);
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        queue_req(i % 250 == 0, MODE_INSERT, k);
      end else if (roll < 50) begin
        queue_req(i % 250 == 0, MODE_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)]);
      end else if (roll < 80) begin
        queue_req(i % 250 == 0, MODE_SEARCH, key_pool[$urandom_range(0, key_pool.size() - 1)]);
      end else if (roll < 96) begin
        queue_req(i % 250 == 0, MODE_SEARCH, k);
      end else begin
        queue_req(i % 250 == 0, logic'($urandom_range(0, 1)), 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d responses never arrived", expected_rsps.size());
      fail_count++;
    end

    $display("ran %0d requests: %0d inserted, %0d already present, %0d full",
             n_accepted, status_seen[CODE_INSERTED], status_seen[CODE_PRESENT],
             status_seen[CODE_FULL]);
    $display("%0d found, %0d not found, %0d zero keys rejected, %0d values held",
             status_seen[CODE_FOUND], status_seen[CODE_NOT_FOUND],
             status_seen[CODE_ZERO], held_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
